// ===== hdl/joystick_differential_drive_pwm_assert.svh =====
// Assertion macros shared by the joystick mixer RTL.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_PWM_ASSERT_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_PWM_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define JDDP_ASSERT_IMPL(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define JDDP_ASSERT_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/jddp_pkg.sv =====
// Types and constants of the joystick differential-drive mixer.
package jddp_pkg;

	localparam logic [11:0] MV_CENTRE   = 12'd1650;
	localparam logic [11:0] MV_MAX      = 12'd3400;
	localparam logic [11:0] LEFT_EDGE   = 12'd1600;
	localparam logic [11:0] RIGHT_EDGE  = 12'd1630;
	localparam logic [11:0] Y_CENTRE_LO = 12'd1620;
	localparam logic [11:0] Y_CENTRE_HI = 12'd1670;
	localparam logic [7:0]  FULL_POWER  = 8'd255;

	localparam int MAG_W  = 11;  // |v - centre| for held values
	localparam int DIV_NW = 19;  // divider numerator width
	localparam int DIV_QW = 9;   // divider quotient width

	// n / 1650 ~= (n * 635) >> 20, low by at most one
	localparam logic [9:0]        RECIP_M    = 10'd635;
	localparam int                RECIP_SH   = 20;
	localparam logic [10:0]       DIVISOR    = 11'd1650;
	localparam logic [DIV_NW-1:0] CEIL_BIAS  = 19'd1649;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	typedef enum logic [1:0] {
		ZONE_LEFT,
		ZONE_RIGHT,
		ZONE_CENTRE,
		ZONE_STRAIGHT
	} zone_t;

	typedef struct packed {
		logic             is_sample;
		logic             fwd;
		zone_t            zone;
		logic [11:0]      x;
		logic [MAG_W-1:0] dx;
		logic [MAG_W-1:0] dy;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PX,
		ST_PY,
		ST_PXR,
		ST_PYR,
		ST_MUL,
		ST_DIV,
		ST_WAIT,
		ST_INNER,
		ST_OUT
	} back_state_t;

endpackage

// ===== hdl/jddp_front.sv =====
// Front end: input transfer, held axis update and zone classification.
module jddp_front import jddp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // x_mv[11:0], y_mv[23:12], x_ok[24], y_ok[25], zero pad
	input  logic        s_tuser,   // kind: 0 tick, 1 sample
	input  logic        q_full,
	output logic        q_push,
	output entry_t      q_entry
);

	logic [11:0] x_held_q, y_held_q;
	logic [11:0] x_in, y_in, x_new, y_new, x_diff, y_diff;
	logic        x_ok, y_ok;

	assign x_in = s_tdata[11:0];
	assign y_in = s_tdata[23:12];
	assign x_ok = s_tdata[24];
	assign y_ok = s_tdata[25];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		x_new = (s_tuser && x_ok && (x_in <= MV_MAX)) ? x_in : x_held_q;
		y_new = (s_tuser && y_ok && (y_in <= MV_MAX)) ? y_in : y_held_q;
		x_diff = (x_new >= MV_CENTRE) ? (x_new - MV_CENTRE) : (MV_CENTRE - x_new);
		y_diff = (y_new >= MV_CENTRE) ? (y_new - MV_CENTRE) : (MV_CENTRE - y_new);

		q_entry.is_sample = s_tuser;
		q_entry.fwd       = (y_new >= MV_CENTRE);
		q_entry.x         = x_new;
		q_entry.dx        = x_diff[MAG_W-1:0];
		q_entry.dy        = y_diff[MAG_W-1:0];
		if (x_new < LEFT_EDGE) begin
			q_entry.zone = ZONE_LEFT;
		end else if (x_new > RIGHT_EDGE) begin
			q_entry.zone = ZONE_RIGHT;
		end else if ((y_new >= Y_CENTRE_LO) && (y_new <= Y_CENTRE_HI)) begin
			q_entry.zone = ZONE_CENTRE;
		end else begin
			q_entry.zone = ZONE_STRAIGHT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_held_q <= MV_CENTRE;
			y_held_q <= MV_CENTRE;
		end else if (q_push && s_tuser) begin
			x_held_q <= x_new;
			y_held_q <= y_new;
		end
	end

endmodule

// ===== hdl/jddp_queue.sv =====
// Short queue of classified items between front and back.
`include "joystick_differential_drive_pwm_assert.svh"
module jddp_queue import jddp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t head,
	output logic   empty
);

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QPTR_W:0]   DEPTH_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

	assign full  = (count_q == DEPTH_CNT);
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`JDDP_ASSERT_IMPL(a_q_fill, clk, arst_n, 1'b1, count_q <= DEPTH_CNT, "queue overfilled")
	`JDDP_ASSERT_IMPL(a_q_underflow, clk, arst_n, pop, count_q != '0, "pop from empty queue")
	`JDDP_ASSERT_NEXT(a_q_push, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "push lost")

endmodule

// ===== hdl/jddp_div1650.sv =====
// Two-stage divide by 1650: reciprocal multiply, then one correction step.
module jddp_div1650 import jddp_pkg::*; (
	input  logic              clk,
	input  logic [DIV_NW-1:0] n,
	output logic [DIV_QW-1:0] q
);

	localparam int PW = DIV_NW + 10;

	logic [DIV_NW-1:0] n_s1;
	logic [PW-1:0]     prod_s1;
	logic [DIV_QW-1:0] q0, q_s2;
	logic [DIV_NW:0]   rem;

	always_comb begin
		q0  = prod_s1[RECIP_SH +: DIV_QW];
		rem = {1'b0, n_s1} - (DIV_NW + 1)'(q0) * (DIV_NW + 1)'(DIVISOR);
	end

	always_ff @(posedge clk) begin
		n_s1    <= n;
		prod_s1 <= PW'(n) * PW'(RECIP_M);
		q_s2    <= (rem >= (DIV_NW + 1)'(DIVISOR)) ? q0 + 1'b1 : q0;
	end

	assign q = q_s2;

endmodule

// ===== hdl/jddp_back.sv =====
// Back end: mix sequencer, duty store, PWM counter and output register.
`include "joystick_differential_drive_pwm_assert.svh"
module jddp_back import jddp_pkg::*; #(
	parameter int PWM_TOP = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  logic        empty,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata
);

	localparam int CW   = $clog2(PWM_TOP + 2);
	localparam int CMPW = (CW > 8) ? CW : 8;

	back_state_t       state_q, state_d;
	entry_t            w_q;
	logic [CW-1:0]     count_q, cnt_inc;
	logic [3:0]        pins_q, tick_pins;
	logic [7:0]        duty_q [4];
	logic [DIV_QW-1:0] px_q;
	logic [7:0]        power_q, power_new;
	logic [DIV_NW-1:0] prod_q, div_n;
	logic [DIV_QW-1:0] div_q, max_p;
	logic [19:0]       prod_full;
	logic [11:0]       mul_a;
	logic [7:0]        r_duty, l_duty, right_inner;
	logic [9:0]        inner_sum;
	logic              out_valid_q, out_free, tick_fire, wrap;
	logic [3:0]        out_pins_q;
	logic [7:0]        out_duty_q [4];

	jddp_div1650 u_div (
		.clk (clk),
		.n   (div_n),
		.q   (div_q)
	);

	assign out_free = !out_valid_q || m_tready;
	assign cnt_inc  = count_q + 1'b1;
	assign wrap     = (cnt_inc > CW'(PWM_TOP));

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			tick_pins[k] = CMPW'(duty_q[k]) > CMPW'(cnt_inc);
		end
	end

	// power from the axis farther from centre
	always_comb begin
		max_p     = (px_q > div_q) ? px_q : div_q;
		power_new = (max_p > DIV_QW'(FULL_POWER)) ? FULL_POWER : max_p[7:0];
		mul_a     = (w_q.zone == ZONE_LEFT) ? w_q.x : 12'(w_q.dx);
		prod_full = mul_a * power_q;
	end

	always_comb begin
		case (state_q)
			ST_PX:   div_n = DIV_NW'({w_q.dx, 8'b0}) - DIV_NW'(w_q.dx);
			ST_PY:   div_n = DIV_NW'({w_q.dy, 8'b0}) - DIV_NW'(w_q.dy);
			ST_DIV:  div_n = (w_q.x >= MV_CENTRE) ? prod_q + CEIL_BIAS : prod_q;
			default: div_n = '0;
		endcase
	end

	// inner wheel of a right turn, and the zone mix
	always_comb begin
		inner_sum = {2'b0, power_q} + 10'(div_q);
		if (w_q.x >= MV_CENTRE) begin
			right_inner = (div_q >= DIV_QW'(power_q)) ? 8'd0 : power_q - div_q[7:0];
		end else begin
			right_inner = (inner_sum > 10'(FULL_POWER)) ? FULL_POWER : inner_sum[7:0];
		end
		case (w_q.zone)
			ZONE_LEFT: begin
				r_duty = power_q;
				l_duty = div_q[7:0];
			end
			ZONE_RIGHT: begin
				r_duty = right_inner;
				l_duty = power_q;
			end
			ZONE_CENTRE: begin
				r_duty = 8'd0;
				l_duty = 8'd0;
			end
			default: begin
				r_duty = power_q;
				l_duty = power_q;
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		tick_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!empty && out_free) begin
					pop = 1'b1;
					if (head.is_sample) begin
						state_d = ST_PX;
					end else begin
						tick_fire = 1'b1;
					end
				end
			end
			ST_PX:    state_d = ST_PY;
			ST_PY:    state_d = ST_PXR;
			ST_PXR:   state_d = ST_PYR;
			ST_PYR:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_DIV;
			ST_DIV:   state_d = ST_WAIT;
			ST_WAIT:  state_d = ST_INNER;
			ST_INNER: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			w_q <= head;
		end
		if (state_q == ST_PXR) begin
			px_q <= div_q;
		end
		if (state_q == ST_PYR) begin
			power_q <= power_new;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_full[DIV_NW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pins_q  <= '0;
			for (int k = 0; k < 4; k++) begin
				duty_q[k] <= '0;
			end
		end else if (tick_fire) begin
			count_q <= wrap ? '0 : cnt_inc;
			pins_q  <= wrap ? 4'hF : tick_pins;
		end else if (state_q == ST_INNER) begin
			duty_q[0] <= w_q.fwd ? r_duty : 8'd0;
			duty_q[1] <= w_q.fwd ? l_duty : 8'd0;
			duty_q[2] <= w_q.fwd ? 8'd0 : r_duty;
			duty_q[3] <= w_q.fwd ? 8'd0 : l_duty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_fire || ((state_q == ST_OUT) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			out_pins_q <= wrap ? 4'hF : tick_pins;
			out_duty_q <= duty_q;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_pins_q <= pins_q;
			out_duty_q <= duty_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_duty_q[3], out_duty_q[2], out_duty_q[1], out_duty_q[0],
		out_pins_q};

	`JDDP_ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(PWM_TOP), "counter past top")
	`JDDP_ASSERT_IMPL(a_dir_zero, clk, arst_n, state_q == ST_OUT, w_q.fwd ? (duty_q[2] == 8'd0 && duty_q[3] == 8'd0) : (duty_q[0] == 8'd0 && duty_q[1] == 8'd0), "unused direction driven")
	`JDDP_ASSERT_NEXT(a_sample_busy, clk, arst_n, pop && head.is_sample, !pop && !m_tvalid || !pop, "pop during mix")

endmodule

// ===== hdl/joystick_differential_drive_pwm.sv =====
// Top level of the joystick differential-drive mixer with PWM outputs.
//
// Every input transfer gives exactly one output transfer. A tick (tuser 0) steps the
// PWM counter, which runs 0..PWM_TOP and wraps with all four pins high; each pin is
// otherwise high while its duty exceeds the stepped counter. A sample (tuser 1)
// updates the held X/Y millivolt values (each only if its ok flag is set and the
// value is at most 3400) and recomputes the four duties; pins and counter stay.
// The front end takes a transfer whenever the two-entry queue has room, so input
// is accepted while the back end works or a result waits on m_tready. A tick is
// handled in the idle state and goes straight to the output register. A sample is
// stepped by its sequencer through PX, PY, PXR, PYR, MUL, DIV, WAIT, INNER and OUT:
// one two-stage divide-by-1650 unit is used three times in turn (X power, Y power,
// inner wheel), with one registered multiply between. Reset brings the held values
// to 1650 mV and counter, pins and duties to zero; there is no clearing pass.
module joystick_differential_drive_pwm import jddp_pkg::*; #(
	parameter int PWM_TOP = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // x_mv[11:0], y_mv[23:12], x_ok[24], y_ok[25], zero pad
	input  logic        s_tuser,   // kind: 0 tick, 1 sample
	output logic        m_tvalid,
	input  logic        m_tready,
	// right_fwd_pin[0], left_fwd_pin[1], right_back_pin[2], left_back_pin[3],
	// right_fwd_duty[11:4], left_fwd_duty[19:12], right_back_duty[27:20],
	// left_back_duty[35:28], zero pad
	output logic [39:0] m_tdata
);

	entry_t push_entry, head;
	logic   push, full, pop, empty;

	// front: input transfer and classification
	jddp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (full),
		.q_push   (push),
		.q_entry  (push_entry)
	);

	// decouples the two sides
	jddp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	// back: mixing, PWM and the output register
	jddp_back #(
		.PWM_TOP (PWM_TOP)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
